/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/sra_pkg.sv */
package sra_pkg;

   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_AGE     = 2'd1;
   localparam logic [1:0] OP_REPORT  = 2'd2;

   localparam logic [2:0] RC_UPDATED  = 3'd0;
   localparam logic [2:0] RC_INSERTED = 3'd1;
   localparam logic [2:0] RC_DROPPED  = 3'd2;
   localparam logic [2:0] RC_IGNORED  = 3'd3;
   localparam logic [2:0] RC_AGED     = 3'd4;
   localparam logic [2:0] RC_REPORT   = 3'd5;
   localparam logic [2:0] RC_EMPTY    = 3'd6;

   localparam logic [16:0] COUNT_LIMIT = 17'd65536;
   localparam int          DIV_STEPS   = 25;

   typedef enum logic [1:0] {
      CMD_OBSERVE,
      CMD_IGNORE,
      CMD_AGE,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [47:0]       src_mac;
      logic signed [7:0] rssi;
   } req_type;

   typedef struct packed {
      logic [2:0]        result_code;
      logic [47:0]       station_mac;
      logic signed [7:0] average_rssi;
      logic [6:0]        entry_count;
      logic [6:0]        removed_count;
      logic              last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [47:0]       mac;
      logic signed [7:0] rssi;
   } cmd_type;

   typedef struct packed {
      logic    empty;
      cmd_type head;
   } queue_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_OBS_RD,
      S_OBS_CMP,
      S_AGE,
      S_AGE_DONE,
      S_REP_RD,
      S_REP_CHK,
      S_REP_DIV
   } back_state_type;

endpackage

/* rtl/station_rssi_aging_table.sv */
// Station RSSI table with aging.
// Input: drive req_word and raise start; the word is taken on a clock edge
// where start is high and busy is low. A two-word queue takes words while
// the table engine works on an earlier one; busy rises when the queue fills.
// Output: each result sits on rsp_word for one cycle with rsp_strobe high;
// the receiver cannot stall, so results are never held. rsp_word.last marks
// the final result of a word.
// Order of work, set by the slot walk over the table memories (one read port each):
//   observe: a read and a compare state per slot until a hit, every slot when the MAC is new;
//   age: visits every slot, then gives its result; ignored word and empty report: answered from idle;
//   report: a read and a check state per slot walked, plus a run of the
//   bit-serial divider that forms the average for each live entry.
// Reset clears the queue, every valid and seen mark and the live count;
// no sweep of the memories is needed, since only valid slots are read.
module station_rssi_aging_table #(
   parameter int ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sra_pkg::req_type req_word,
   output logic             rsp_strobe,
   output sra_pkg::rsp_type rsp_word
);

   // queue status from front to back, and the pop back to the front
   sra_pkg::queue_status_type status;
   logic                      pop;

   // accept and classify incoming words
   sra_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .busy     (busy),
      .pop      (pop),
      .status   (status)
   );

   // walk the table and drive results
   sra_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

/* rtl/sra_front.sv */
module sra_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  sra_pkg::req_type          req_word,
   output logic                      busy,
   input  logic                      pop,
   output sra_pkg::queue_status_type status
);

   sra_pkg::cmd_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   sra_pkg::cmd_type cmd;

   // classify the incoming word
   always_comb begin
      cmd.mac  = req_word.src_mac;
      cmd.rssi = req_word.rssi;
      unique case (req_word.opcode)
         sra_pkg::OP_OBSERVE: begin
            cmd.kind = req_word.rssi[7] ? sra_pkg::CMD_OBSERVE : sra_pkg::CMD_IGNORE;
         end
         sra_pkg::OP_AGE:    cmd.kind = sra_pkg::CMD_AGE;
         sra_pkg::OP_REPORT: cmd.kind = sra_pkg::CMD_REPORT;
         default:            cmd.kind = sra_pkg::CMD_IGNORE;
      endcase
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign status.empty = (count_ff == 2'd0);
   assign status.head  = queue_ff[rd_ptr_ff];

endmodule

/* rtl/sra_div.sv */
module sra_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [24:0] dividend,
   input  logic [16:0]        divisor,
   output logic               done,
   output logic signed [7:0]  quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [4:0]  step_ff, step_in;
   logic [17:0] rem_ff, rem_in;
   logic [24:0] quo_ff, quo_in;
   logic [17:0] rem_sh;
   logic [24:0] quo_neg;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff[16:0], quo_ff[24]};
      if (start) begin
         run_in  = 1'b1;
         neg_in  = dividend[24];
         step_in = 5'd0;
         rem_in  = 18'd0;
         quo_in  = dividend[24] ? 25'(-dividend) : 25'(dividend);
      end else if (run_ff) begin
         // one quotient bit per cycle
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = rem_sh - {1'b0, divisor};
            quo_in = {quo_ff[23:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[23:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(sra_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign quo_neg  = -quo_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? quo_neg[7:0] : quo_ff[7:0];

endmodule

/* rtl/sra_back.sv */
`include "assert_macros.svh"

module sra_back #(
   parameter int ENTRIES = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sra_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_strobe,
   output sra_pkg::rsp_type          rsp_word
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   sra_pkg::back_state_type state_ff, state_in;
   sra_pkg::cmd_type   cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               free_found_ff, free_found_in;
   logic [6:0]         removed_ff, removed_in;
   logic [6:0]         live_ff, live_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] seen_ff, seen_in;
   logic               strobe_ff, strobe_in;
   sra_pkg::rsp_type   rsp_ff, rsp_in;

   logic [47:0]        mac_mem [ENTRIES];
   logic signed [24:0] sum_mem [ENTRIES];
   logic [16:0]        cnt_mem [ENTRIES];
   logic [47:0]        mac_rd_ff;
   logic signed [24:0] sum_rd_ff;
   logic [16:0]        cnt_rd_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [47:0]        wr_mac;
   logic signed [24:0] wr_sum;
   logic [16:0]        wr_cnt;

   logic               div_start, div_done;
   logic signed [7:0]  div_q;
   logic signed [24:0] rssi_ext;
   logic [ENTRIES-1:0] valid_above;
   logic               more;
   logic               hit;

   sra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_rd_ff),
      .divisor  (cnt_rd_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rssi_ext    = {{17{cmd_ff.rssi[7]}}, cmd_ff.rssi};
   assign valid_above = (valid_ff >> idx_ff) >> 1;
   assign more        = |valid_above;
   assign hit         = valid_ff[idx_ff] && (mac_rd_ff == cmd_ff.mac);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      removed_in    = removed_ff;
      live_in       = live_ff;
      valid_in      = valid_ff;
      seen_in       = seen_ff;
      strobe_in     = 1'b0;
      rsp_in        = '0;
      rsp_in.entry_count = live_ff;
      rsp_in.last   = 1'b1;
      pop           = 1'b0;
      div_start     = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_mac        = cmd_ff.mac;
      wr_sum        = rssi_ext;
      wr_cnt        = 17'd1;
      unique case (state_ff)
         sra_pkg::S_IDLE: begin
            if (!status.empty) begin
               pop           = 1'b1;
               cmd_in        = status.head;
               idx_in        = '0;
               free_found_in = 1'b0;
               removed_in    = 7'd0;
               unique case (status.head.kind)
                  sra_pkg::CMD_OBSERVE: state_in = sra_pkg::S_OBS_RD;
                  sra_pkg::CMD_AGE:     state_in = sra_pkg::S_AGE;
                  sra_pkg::CMD_REPORT: begin
                     if (live_ff == 7'd0) begin
                        strobe_in          = 1'b1;
                        rsp_in.result_code = sra_pkg::RC_EMPTY;
                     end else begin
                        state_in = sra_pkg::S_REP_RD;
                     end
                  end
                  default: begin
                     strobe_in          = 1'b1;
                     rsp_in.result_code = sra_pkg::RC_IGNORED;
                  end
               endcase
            end
         end
         sra_pkg::S_OBS_RD: state_in = sra_pkg::S_OBS_CMP;
         sra_pkg::S_OBS_CMP: begin
            if (hit) begin
               wr_en = 1'b1;
               if (cnt_rd_ff <= sra_pkg::COUNT_LIMIT) begin
                  wr_sum = sum_rd_ff + rssi_ext;
                  wr_cnt = cnt_rd_ff + 17'd1;
               end
               seen_in[idx_ff]    = 1'b1;
               strobe_in          = 1'b1;
               rsp_in.result_code = sra_pkg::RC_UPDATED;
               rsp_in.station_mac = cmd_ff.mac;
               state_in           = sra_pkg::S_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               state_in  = sra_pkg::S_IDLE;
               strobe_in = 1'b1;
               if (free_found_ff || !valid_ff[idx_ff]) begin
                  wr_en              = 1'b1;
                  wr_idx             = free_found_ff ? free_idx_ff : idx_ff;
                  valid_in[wr_idx]   = 1'b1;
                  seen_in[wr_idx]    = 1'b1;
                  live_in            = live_ff + 7'd1;
                  rsp_in.result_code = sra_pkg::RC_INSERTED;
                  rsp_in.station_mac = cmd_ff.mac;
                  rsp_in.entry_count = live_ff + 7'd1;
               end else begin
                  rsp_in.result_code = sra_pkg::RC_DROPPED;
               end
            end else begin
               if (!valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               idx_in   = idx_ff + IDX_W'(1);
               state_in = sra_pkg::S_OBS_RD;
            end
         end
         sra_pkg::S_AGE: begin
            if (valid_ff[idx_ff]) begin
               if (seen_ff[idx_ff]) begin
                  seen_in[idx_ff] = 1'b0;
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  removed_in       = removed_ff + 7'd1;
                  live_in          = live_ff - 7'd1;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = sra_pkg::S_AGE_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         sra_pkg::S_AGE_DONE: begin
            strobe_in            = 1'b1;
            rsp_in.result_code   = sra_pkg::RC_AGED;
            rsp_in.removed_count = removed_ff;
            state_in             = sra_pkg::S_IDLE;
         end
         sra_pkg::S_REP_RD: state_in = sra_pkg::S_REP_CHK;
         sra_pkg::S_REP_CHK: begin
            if (valid_ff[idx_ff]) begin
               div_start = 1'b1;
               state_in  = sra_pkg::S_REP_DIV;
            end else if (idx_ff == LAST_IDX) begin
               state_in = sra_pkg::S_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = sra_pkg::S_REP_RD;
            end
         end
         sra_pkg::S_REP_DIV: begin
            if (div_done) begin
               strobe_in           = 1'b1;
               rsp_in.result_code  = sra_pkg::RC_REPORT;
               rsp_in.station_mac  = mac_rd_ff;
               rsp_in.average_rssi = div_q;
               rsp_in.last         = !more;
               if (more) begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = sra_pkg::S_REP_RD;
               end else begin
                  state_in = sra_pkg::S_IDLE;
               end
            end
         end
         default: state_in = sra_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sra_pkg::S_IDLE;
         live_ff   <= 7'd0;
         valid_ff  <= '0;
         seen_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         live_ff   <= live_in;
         valid_ff  <= valid_in;
         seen_ff   <= seen_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      free_idx_ff   <= free_idx_in;
      free_found_ff <= free_found_in;
      removed_ff    <= removed_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mac_mem[wr_idx] <= wr_mac;
         sum_mem[wr_idx] <= wr_sum;
         cnt_mem[wr_idx] <= wr_cnt;
      end
      mac_rd_ff <= mac_mem[idx_ff];
      sum_rd_ff <= sum_mem[idx_ff];
      cnt_rd_ff <= cnt_mem[idx_ff];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   `SRA_ASSERT_IMPLY(a_live_bound, clock, reset, 1'b1, live_ff <= 7'(ENTRIES))
   `SRA_ASSERT_IMPLY(a_insert_live, clock, reset,
      strobe_ff && rsp_ff.result_code == sra_pkg::RC_INSERTED, rsp_ff.entry_count != 7'd0)
   `SRA_ASSERT_NEXT(a_pop_leaves_idle, clock, reset,
      state_ff == sra_pkg::S_IDLE && !status.empty, state_ff != sra_pkg::S_IDLE || strobe_ff)

endmodule
